>>> design/mpms_pkg.sv
package mpms_pkg;

  localparam int MaxLimbs = 32;
  localparam int LimbW = 64;
  localparam int IdxW = $clog2(MaxLimbs);
  localparam int CntW = 6;
  localparam int ProdIdxW = 6;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_SQR = 1'b1;

  typedef logic [LimbW-1:0] limb_t;

  // Control register for the product output stream: valid, limb index and last flag.
  typedef struct packed {
    logic             vld;
    logic [IdxW:0]    idx;
    logic             last;
  } mpms_ctl_t;

endpackage

>>> design/mpms_ram.sv
module mpms_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mpms_lane.sv
// One multiply lane: registers a 64x64 product as four 32x32 partial products
// and sums them combinationally; the unit adds accumulator and carry in the next cycle.
module mpms_lane
  import mpms_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  limb_t        x,
  input  limb_t        y,
  output logic [127:0] prod
);

  logic [63:0] p00_r, p01_r, p10_r, p11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= 64'(x[31:0])  * 64'(y[31:0]);
      p01_r <= 64'(x[31:0])  * 64'(y[63:32]);
      p10_r <= 64'(x[63:32]) * 64'(y[31:0]);
      p11_r <= 64'(x[63:32]) * 64'(y[63:32]);
    end
  end

  assign prod = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
              + {p11_r, 64'd0};

endmodule

>>> design/multiprecision_multiply_square_unit.sv
// Schoolbook multiprecision multiply/square. Set limb_count (0 acts as 1,
// above 32 saturates to 32) through the cfg channel while busy is low; cfg_ready
// also stays low in a cycle where start is high, so a limb pair always wins.
// A count write discards limbs gathered so far. Each start transfer brings one
// limb pair, least significant first, and pairs are taken one per cycle while
// busy is low; operation on the first pair selects a*b or a*a. After the last
// pair, busy stays high while two multiply lanes work each row of N partial
// products one column pair at a time. Each pair takes a multiply step and then
// an accumulate step through the product RAM, and each row ends with an S_TOP
// step that stores its top carry. The 2N product limbs then stream out on
// consecutive cycles with out_valid, and last marks the top limb. Busy drops
// as the top limb appears. Results cannot be stalled: the receiver must take a
// limb every cycle that out_valid is high.
module multiprecision_multiply_square_unit
  import mpms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [LimbW-1:0]    in_a_limb,
  input  logic [LimbW-1:0]    in_b_limb,
  input  logic                in_operation,
  output logic                out_valid,
  output logic [LimbW-1:0]    out_product_limb,
  output logic [ProdIdxW-1:0] out_limb_index,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CntW-1:0]     cfg_limb_count
);

  // The operand stores are flip-flop rows that the lanes read at computed
  // columns. The product store sits in two RAM banks split by column parity,
  // so the two lanes never compete for a port.
  typedef enum logic [1:0] {S_LOAD, S_MUL, S_TOP, S_OUT} state_t;

  state_t          state_r;
  logic [IdxW:0]   n_r;
  logic [IdxW:0]   rcv_r;
  logic            sqr_r;
  limb_t           a_r [MaxLimbs];
  limb_t           b_r [MaxLimbs];
  logic [IdxW:0]   j_r;       // row (b limb)
  logic [IdxW:0]   i_r;       // column pair base for issue
  logic            ph_r;      // 0: issue multiply, 1: accumulate
  limb_t           carry_r;
  logic [ProdIdxW:0] k_r;
  mpms_ctl_t       ctl_r;

  logic [IdxW:0]   n_eff;
  always_comb begin
    if (cfg_limb_count == '0) n_eff = (IdxW+1)'(1);
    else if (cfg_limb_count > CntW'(MaxLimbs)) n_eff = (IdxW+1)'(MaxLimbs);
    else n_eff = (IdxW+1)'(cfg_limb_count);
  end

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD) && !start;

  // Two lanes: column i and column i+1 of the current row.
  limb_t        ybj;
  limb_t        x0, x1;
  logic [127:0] pr0, pr1;
  logic [IdxW-1:0] i0, i1;
  logic            v1;

  assign i0  = i_r[IdxW-1:0];
  assign i1  = i0 + IdxW'(1);
  assign v1  = (i_r + (IdxW+1)'(1)) < n_r;
  assign ybj = sqr_r ? a_r[j_r[IdxW-1:0]] : b_r[j_r[IdxW-1:0]];
  assign x0  = a_r[i0];
  assign x1  = v1 ? a_r[i1] : '0;

  mpms_lane u_lane0 (.clk(clk), .en(!ph_r), .x(x0), .y(ybj), .prod(pr0));
  mpms_lane u_lane1 (.clk(clk), .en(!ph_r), .x(x1), .y(ybj), .prod(pr1));

  // Product banks: even columns in one, odd columns in the other.
  logic            pe_we, po_we;
  logic [IdxW-1:0] pe_waddr, po_waddr, pe_raddr, po_raddr;
  limb_t           pe_wdata, po_wdata, pe_rdata, po_rdata;

  mpms_ram #(.Width(LimbW), .Depth(MaxLimbs)) u_prod_even (
    .clk(clk), .we(pe_we), .waddr(pe_waddr), .wdata(pe_wdata),
    .raddr(pe_raddr), .rdata(pe_rdata)
  );
  mpms_ram #(.Width(LimbW), .Depth(MaxLimbs)) u_prod_odd (
    .clk(clk), .we(po_we), .waddr(po_waddr), .wdata(po_wdata),
    .raddr(po_raddr), .rdata(po_rdata)
  );

  // Merge: add accumulators and chain the carry across the two lanes.
  // The column pair base is always even, so lane 0 sits in the bank that
  // matches the parity of the row. Row 0 starts from an empty product.
  logic [ProdIdxW-1:0] c0, c1, ct;
  limb_t        acc0, acc1;
  logic [128:0] s0, s1;
  limb_t        top_c;
  assign c0   = ProdIdxW'(i_r) + ProdIdxW'(j_r);
  assign c1   = c0 + ProdIdxW'(1);
  assign ct   = ProdIdxW'(n_r) + ProdIdxW'(j_r);
  assign acc0 = (j_r == '0) ? '0 : (j_r[0] ? po_rdata : pe_rdata);
  assign acc1 = (j_r == '0) ? '0 : (j_r[0] ? pe_rdata : po_rdata);
  assign s0   = {1'b0, pr0} + 129'(acc0) + 129'(carry_r);
  assign s1   = {1'b0, pr1} + 129'(acc1) + 129'(s0[127:64]);
  assign top_c = v1 ? s1[127:64] : s0[127:64];

  always_comb begin
    pe_raddr = j_r[0] ? c1[ProdIdxW-1:1] : c0[ProdIdxW-1:1];
    po_raddr = j_r[0] ? c0[ProdIdxW-1:1] : c1[ProdIdxW-1:1];
    if (state_r == S_OUT) begin
      pe_raddr = k_r[ProdIdxW-1:1];
      po_raddr = k_r[ProdIdxW-1:1];
    end
  end

  always_comb begin
    pe_we    = 1'b0;
    po_we    = 1'b0;
    pe_waddr = c0[ProdIdxW-1:1];
    po_waddr = c0[ProdIdxW-1:1];
    pe_wdata = s0[63:0];
    po_wdata = s0[63:0];
    if (state_r == S_MUL && ph_r) begin
      if (j_r[0]) begin
        po_we    = 1'b1;
        po_waddr = c0[ProdIdxW-1:1];
        po_wdata = s0[63:0];
        pe_we    = v1;
        pe_waddr = c1[ProdIdxW-1:1];
        pe_wdata = s1[63:0];
      end else begin
        pe_we    = 1'b1;
        pe_waddr = c0[ProdIdxW-1:1];
        pe_wdata = s0[63:0];
        po_we    = v1;
        po_waddr = c1[ProdIdxW-1:1];
        po_wdata = s1[63:0];
      end
    end else if (state_r == S_TOP) begin
      pe_we    = !ct[0];
      po_we    = ct[0];
      pe_waddr = ct[ProdIdxW-1:1];
      po_waddr = ct[ProdIdxW-1:1];
      pe_wdata = carry_r;
      po_wdata = carry_r;
    end
  end

  logic row_end;
  assign row_end = (i_r + (IdxW+1)'(2)) >= n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r     <= (IdxW+1)'(1);
      rcv_r   <= '0;
      sqr_r   <= OP_MUL;
      ctl_r   <= '0;
      ph_r    <= 1'b0;
    end else begin
      ctl_r.vld <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (start) begin
            a_r[rcv_r[IdxW-1:0]] <= in_a_limb;
            b_r[rcv_r[IdxW-1:0]] <= in_b_limb;
            if (rcv_r == '0) sqr_r <= in_operation;
            if (rcv_r + (IdxW+1)'(1) >= n_r) begin
              rcv_r   <= '0;
              state_r <= S_MUL;
              i_r     <= '0;
              j_r     <= '0;
              ph_r    <= 1'b0;
              carry_r <= '0;
            end else begin
              rcv_r <= rcv_r + (IdxW+1)'(1);
            end
          end else if (cfg_valid) begin
            n_r   <= n_eff;
            rcv_r <= '0;
          end
        end
        S_MUL: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            carry_r <= top_c;
            if (row_end) begin
              state_r <= S_TOP;
            end else begin
              i_r <= i_r + (IdxW+1)'(2);
            end
          end
        end
        S_TOP: begin
          // The row's top carry goes to column n+j in this cycle.
          carry_r <= '0;
          i_r     <= '0;
          if (j_r + (IdxW+1)'(1) >= n_r) begin
            state_r <= S_OUT;
            k_r     <= '0;
          end else begin
            j_r     <= j_r + (IdxW+1)'(1);
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          ctl_r.vld  <= 1'b1;
          ctl_r.idx  <= k_r[IdxW:0];
          ctl_r.last <= (k_r + (ProdIdxW+1)'(1)) == ((ProdIdxW+1)'(n_r) << 1);
          if ((k_r + (ProdIdxW+1)'(1)) == ((ProdIdxW+1)'(n_r) << 1)) begin
            state_r <= S_LOAD;
          end
          k_r <= k_r + (ProdIdxW+1)'(1);
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid        = ctl_r.vld;
  assign out_product_limb = ctl_r.idx[0] ? po_rdata : pe_rdata;
  assign out_limb_index   = ProdIdxW'(ctl_r.idx);
  assign out_last         = ctl_r.last;

endmodule

>>> design/mpms_checker.sv
module mpms_checker
  import mpms_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [ProdIdxW-1:0] out_limb_index,
  input logic                out_last,
  input logic                cfg_ready
);

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == (!busy && !start)) else $error("cfg ready while busy or on a start");

  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_limb_index == '0)
    else $error("product stream does not start at limb zero");

  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("product stream broken");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after last limb");

endmodule

bind multiprecision_multiply_square_unit mpms_checker u_mpms_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_limb_index(out_limb_index),
  .out_last(out_last), .cfg_ready(cfg_ready)
);

>>> test/tb_multiprecision_multiply_square_unit.sv
module tb_multiprecision_multiply_square_unit;
  import mpms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    limb_t a;
    limb_t b;
    logic  op;
  } limb_pair_t;

  typedef struct {
    limb_t                limb;
    logic [ProdIdxW-1:0]  idx;
    logic                 last;
  } product_limb_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [LimbW-1:0]    in_a_limb = '0;
  logic [LimbW-1:0]    in_b_limb = '0;
  logic                in_operation = OP_MUL;
  logic                out_valid;
  logic [LimbW-1:0]    out_product_limb;
  logic [ProdIdxW-1:0] out_limb_index;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CntW-1:0]     cfg_limb_count = '0;

  multiprecision_multiply_square_unit i_dut (.*);

  always #1 clk = ~clk;

  limb_pair_t    pair_q[$];
  product_limb_t product_q[$];
  int            errors = 0;
  int            gap_left = 0;
  int            gap_max = 12;
  int            queued = 0;

  // Predictor state, mirrors the block.
  logic [CntW-1:0] count_reg = 6'd1;
  int              limbs_held = 0;
  logic            squaring = 1'b0;
  limb_t           a_store[MaxLimbs];
  limb_t           b_store[MaxLimbs];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int used_limbs(input logic [CntW-1:0] c);
    if (c == 0) return 1;
    if (c > MaxLimbs) return MaxLimbs;
    return int'(c);
  endfunction

  task automatic absorb_pair(input limb_t a, input limb_t b, input logic op);
    int             n;
    limb_t          prod[2*MaxLimbs];
    limb_t          mult;
    limb_t          carry;
    logic [127:0]   t;
    product_limb_t  p;
    n = used_limbs(count_reg);
    if (limbs_held >= n) limbs_held = 0;
    if (limbs_held == 0) squaring = op;
    a_store[limbs_held] = a;
    b_store[limbs_held] = b;
    limbs_held++;
    if (limbs_held < n) return;
    limbs_held = 0;
    for (int k = 0; k < 2*n; k++) prod[k] = '0;
    for (int j = 0; j < n; j++) begin
      mult = (squaring == OP_SQR) ? a_store[j] : b_store[j];
      carry = '0;
      for (int i = 0; i < n; i++) begin
        t = {64'd0, a_store[i]} * {64'd0, mult} + {64'd0, prod[i+j]} + {64'd0, carry};
        prod[i+j] = t[63:0];
        carry = t[127:64];
      end
      prod[n+j] = carry;
    end
    for (int k = 0; k < 2*n; k++) begin
      p.limb = prod[k];
      p.idx = ProdIdxW'(k);
      p.last = (k == 2*n-1);
      product_q.push_back(p);
    end
  endtask

  // Driver: a start held against busy stays put until the transfer happens.
  always @(posedge clk) begin
    limb_pair_t item;
    if (rst_n) begin
      if (start && !busy) absorb_pair(in_a_limb, in_b_limb, in_operation);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pair_q.size() > 0) begin
          item = pair_q.pop_front();
          in_a_limb <= item.a;
          in_b_limb <= item.b;
          in_operation <= item.op;
          start <= 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    product_limb_t e;
    if (rst_n && out_valid) begin
      if (product_q.size() == 0) begin
        report($sformatf("unexpected product limb %h idx %0d", out_product_limb,
                         out_limb_index));
      end else begin
        e = product_q.pop_front();
        if (out_product_limb !== e.limb)
          report($sformatf("limb %0d: got %h, want %h", e.idx, out_product_limb, e.limb));
        if (out_limb_index !== e.idx)
          report($sformatf("index: got %0d, want %0d", out_limb_index, e.idx));
        if (out_last !== e.last)
          report($sformatf("last on limb %0d: got %b, want %b", e.idx, out_last, e.last));
      end
    end
  end

  function automatic limb_t pick_limb();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_idle();
    while (pair_q.size() > 0 || start || product_q.size() > 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(input logic [CntW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_limb_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_reg = v;
    limbs_held = 0;
    cfg_valid <= 1'b0;
  endtask

  // Queues whole operands (all ones, all zeros or random content, by kind), then optionally a partial one.
  task automatic queue_operands(input int ops, input bit partial, input int kind);
    limb_pair_t it;
    int n;
    int total;
    n = used_limbs(count_reg);
    total = ops * n + (partial ? $urandom_range(1, n) - 1 : 0);
    for (int k = 0; k < total; k++) begin
      case (kind)
        1: begin it.a = '1; it.b = '1; end
        2: begin it.a = '0; it.b = '0; end
        default: begin it.a = pick_limb(); it.b = pick_limb(); end
      endcase
      it.op = 1'($urandom_range(0, 1));
      pair_q.push_back(it);
      queued++;
    end
    wait_idle();
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes at one limb, zero and oversized counts, mid-operand write.
    queue_operands(3, 0, 1);
    queue_operands(2, 0, 2);
    write_count(6'd0);
    queue_operands(3, 0, 0);
    write_count(6'd63);
    queue_operands(1, 0, 1);
    write_count(6'd3);
    pair_q.push_back('{a: '1, b: '1, op: OP_MUL});
    pair_q.push_back('{a: '1, b: '1, op: OP_MUL});
    queued += 2;
    wait_idle();
    write_count(6'd2);
    queue_operands(2, 0, 1);
    write_count(6'd21);
    queue_operands(1, 0, 0);
    write_count(6'd42);
    queue_operands(1, 0, 0);

    while (queued < 480) begin
      r = $urandom_range(0, 19);
      if (r == 0) write_count(6'd0);
      else if (r == 1) write_count(6'($urandom_range(33, 63)));
      else if (r == 2) write_count(6'd32);
      else write_count(6'($urandom_range(1, 8)));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      queue_operands(used_limbs(count_reg) > 8 ? 1 : $urandom_range(1, 4),
                     $urandom_range(0, 3) == 0, 0);
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
design/mpms_pkg.sv
design/mpms_ram.sv
design/mpms_lane.sv
design/multiprecision_multiply_square_unit.sv
design/mpms_checker.sv
test/tb_multiprecision_multiply_square_unit.sv
